/* sv/wpr_pkg.sv */
package wpr_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int DATA_W     = 32;
  localparam int CS_W       = 40;
  localparam int SUM_W      = 48;
  localparam int TOT_W      = 50;
  localparam int DIV_DVD_W  = 64;
  localparam int DIV_DSR_W  = 48;
  localparam int DIV_REM_W  = 50;
  localparam int DIV_STEP_W = 7;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_DVD_W-1:0]  dividend;
    logic [DIV_DSR_W-1:0]  divisor;
    logic [DIV_STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

/* sv/wpr_div.sv */
// Restoring divider, one quotient bit per cycle. The remainder starts at
// rem_init and takes dividend bits from the top down.
module wpr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wpr_pkg::div_req_t req,
  output wpr_pkg::div_rsp_t rsp
);

  logic [wpr_pkg::DIV_REM_W-1:0]  rem_r;
  logic [wpr_pkg::DIV_DVD_W-1:0]  dvd_r;
  logic [wpr_pkg::DIV_DVD_W-1:0]  q_r;
  logic [wpr_pkg::DIV_DSR_W-1:0]  dsr_r;
  logic [wpr_pkg::DIV_STEP_W-1:0] cnt_r;
  logic                           done_r;

  logic [wpr_pkg::DIV_REM_W-1:0] rem_sh;
  logic [wpr_pkg::DIV_REM_W-1:0] dsr_ext;
  logic                          fits;

  always_comb begin
    rem_sh  = {rem_r[wpr_pkg::DIV_REM_W-2:0], dvd_r[wpr_pkg::DIV_DVD_W-1]};
    dsr_ext = wpr_pkg::DIV_REM_W'(dsr_r);
    fits    = rem_sh >= dsr_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.steps;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wpr_pkg::DIV_STEP_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? rem_sh - dsr_ext : rem_sh;
      dvd_r <= {dvd_r[wpr_pkg::DIV_DVD_W-2:0], 1'b0};
      q_r   <= {q_r[wpr_pkg::DIV_DVD_W-2:0], fits};
    end
  end

  assign rsp.busy = cnt_r != '0;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

/* sv/weighted_pagerank_power_iteration_core.sv */
// Weighted rank engine: power iteration over a symmetric gain matrix.
// Input channel (in_valid / in_stall): a word with in_req_type 0 writes one
// gain element G[row][col]; only row <= col and the diagonal are
// used. A word with in_req_type 1 starts a run; in_stall stays high until the
// run has placed its last result in the output register.
// Output channel (out_valid / out_stall): one word per node in descending
// score order (lower index first on ties), last_of_run on the final one. A
// zero trace gives one word with error_flag set.
// A run goes through column sums, the transition build (up to two
// divisions per element on the shared divider), the passes (matrix-vector
// stream plus at most one division per node) and the sort.
// The shared divider and the single-port memory reads set the run length.
// The output register holds a result while out_stall is high; the sequencer
// waits on it, and the input side may take the next word once the last result
// is registered.
// Reset (rst_n low, synchronous) clears control state and loads register
// defaults; stores are undefined until written, so no clearing pass runs.
// cfg_we writes register cfg_index (0 damping, 1 threshold, 2 nodes, 3 limit).
module weighted_pagerank_power_iteration_core #(
  parameter int MAX_NODES = wpr_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [5:0]         in_row_index,
  input  logic [5:0]         in_col_index,
  input  logic signed [31:0] in_gain_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_node_index,
  output logic [31:0]        out_rank_score,
  output logic signed [31:0] out_info_gain,
  output logic               out_last_of_run,
  output logic               out_converged,
  output logic               out_error_flag
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int GAW = 2 * AW;
  localparam int RAW = AW + 1;
  localparam int CSW = wpr_pkg::CS_W;
  localparam int SW  = wpr_pkg::SUM_W;
  localparam int TW  = wpr_pkg::TOT_W;

  localparam logic [1:0] CFG_DAMPING = 2'd0;
  localparam logic [1:0] CFG_THRESH  = 2'd1;
  localparam logic [1:0] CFG_NODES   = 2'd2;
  localparam logic [1:0] CFG_LIMIT   = 2'd3;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_CS_RD   = 5'd1;
  localparam logic [4:0] ST_CS_ACC  = 5'd2;
  localparam logic [4:0] ST_TR_CHK  = 5'd3;
  localparam logic [4:0] ST_ERR_OUT = 5'd4;
  localparam logic [4:0] ST_TB_D1   = 5'd5;
  localparam logic [4:0] ST_TB_D2   = 5'd6;
  localparam logic [4:0] ST_TB_RD   = 5'd7;
  localparam logic [4:0] ST_TB_MUL  = 5'd8;
  localparam logic [4:0] ST_TB_DA   = 5'd9;
  localparam logic [4:0] ST_TB_DAW  = 5'd10;
  localparam logic [4:0] ST_TB_DB   = 5'd11;
  localparam logic [4:0] ST_TB_DBW  = 5'd12;
  localparam logic [4:0] ST_IN_DIV  = 5'd13;
  localparam logic [4:0] ST_IN_DIVW = 5'd14;
  localparam logic [4:0] ST_IN_WR   = 5'd15;
  localparam logic [4:0] ST_MV      = 5'd16;
  localparam logic [4:0] ST_NM_RD   = 5'd17;
  localparam logic [4:0] ST_NM_CALC = 5'd18;
  localparam logic [4:0] ST_NM_WAIT = 5'd19;
  localparam logic [4:0] ST_NM_WR   = 5'd20;
  localparam logic [4:0] ST_SR_RD   = 5'd21;
  localparam logic [4:0] ST_SR_CMP  = 5'd22;
  localparam logic [4:0] ST_SR_G1   = 5'd23;
  localparam logic [4:0] ST_SR_G2   = 5'd24;

  // Configuration registers
  logic [15:0] damp_r;
  logic [31:0] thr_r;
  logic [6:0]  nodes_r;
  logic [15:0] iter_r;

  // Sequencer state
  logic [4:0]           state_r, state_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [15:0]          limit_r, limit_nxt;
  logic [AW-1:0]        i_r, i_nxt, j_r, j_nxt;
  logic [AW-1:0]        nm1;
  logic signed [CSW-1:0] trace_r, trace_nxt, acc_r, acc_nxt;
  logic signed [31:0]   d_r, d_nxt;
  logic signed [48:0]   pa_r, pa_nxt;
  logic signed [49:0]   pb_r, pb_nxt;
  logic signed [CSW-1:0] cs_r, cs_nxt;
  logic signed [63:0]   a_r, a_nxt;
  logic                 neg_r, neg_nxt;
  logic [31:0]          init_r, init_nxt;
  logic                 bank_r, bank_nxt;
  logic [15:0]          pass_r, pass_nxt;
  logic                 conv_r, conv_nxt;
  logic                 iss_r, iss_nxt;
  logic signed [TW-1:0] total_r, total_nxt;
  logic [31:0]          new_r, new_nxt;
  logic [31:0]          prev_r, prev_nxt;
  logic [MAX_NODES-1:0] taken_r, taken_nxt;
  logic [31:0]          best_r, best_nxt;
  logic [AW-1:0]        bidx_r, bidx_nxt;
  logic                 hit_r, hit_nxt;
  logic [AW-1:0]        rnd_r, rnd_nxt;

  // Matrix-vector stream
  logic                 s1_v_r, s1_first_r, s1_last_r;
  logic [AW-1:0]        s1_i_r;
  logic                 s2_v_r, s2_first_r, s2_last_r;
  logic [AW-1:0]        s2_i_r;
  logic signed [63:0]   prod_r;
  logic signed [SW-1:0] mvacc_r, mvacc_nxt;
  logic signed [SW-1:0] term;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic [5:0]  o_node_nxt;
  logic [31:0] o_score_nxt;
  logic [31:0] o_gain_nxt;
  logic        o_last_nxt, o_conv_nxt, o_err_nxt;
  logic        out_free;

  // Memories
  logic [31:0]     gmem [0:(1 << GAW) - 1];
  logic [31:0]     tmem [0:(1 << GAW) - 1];
  logic [CSW-1:0]  csmem [0:(1 << AW) - 1];
  logic [SW-1:0]   smem [0:(1 << AW) - 1];
  logic [31:0]     rmem [0:(1 << RAW) - 1];
  logic [31:0]     gmem_rd, tmem_rd, rmem_rd;
  logic [CSW-1:0]  csmem_rd;
  logic [SW-1:0]   smem_rd;
  logic            g_we, t_we, cs_we, s_we, r_we;
  logic [GAW-1:0]  g_wa, g_ra;
  logic [31:0]     t_wd, r_wd;
  logic [CSW-1:0]  cs_wd;
  logic [SW-1:0]   s_wd;
  logic [RAW-1:0]  r_wa, r_ra;

  wpr_pkg::div_req_t div_req;
  wpr_pkg::div_rsp_t div_rsp;

  wpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Working values
  logic signed [31:0]   g;
  logic [16:0]          wgt;
  logic [48:0]          pa_mag;
  logic [49:0]          pb_mag;
  logic [CSW-1:0]       cs_mag, tr_mag;
  logic signed [63:0]   qs, tsum;
  logic signed [SW-1:0] y;
  logic [TW-1:0]        y_mag, tot_mag;
  logic [31:0]          diff;
  logic [GAW-1:0]       sym_addr;
  logic                 in_acc;

  assign nm1      = AW'(n_r - 1'b1);
  assign g        = $signed(gmem_rd);
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state_r != ST_IDLE;
  assign out_free = !out_valid_r || !out_stall;
  assign sym_addr = (i_r <= j_r) ? {i_r, j_r} : {j_r, i_r};

  assign pa_mag  = pa_r[48] ? 49'(-pa_r) : 49'(pa_r);
  assign pb_mag  = pb_r[49] ? 50'(-pb_r) : 50'(pb_r);
  assign cs_mag  = cs_r[CSW-1] ? CSW'(-cs_r) : CSW'(cs_r);
  assign tr_mag  = trace_r[CSW-1] ? CSW'(-trace_r) : CSW'(trace_r);
  assign qs      = neg_r ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
  assign tsum    = a_r + qs;
  assign y       = $signed(smem_rd);
  assign y_mag   = y[SW-1] ? TW'(-y) : TW'(y);
  assign tot_mag = total_r[TW-1] ? TW'(-total_r) : TW'(total_r);
  assign diff    = (new_r >= prev_r) ? new_r - prev_r : prev_r - new_r;
  assign term    = SW'(prod_r >>> 28);

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r  <= 16'd55706;
      thr_r   <= 32'd429497;
      nodes_r <= 7'd64;
      iter_r  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAMPING: damp_r  <= cfg_wdata[15:0];
        CFG_THRESH:  thr_r   <= cfg_wdata;
        CFG_NODES:   nodes_r <= cfg_wdata[6:0];
        CFG_LIMIT:   iter_r  <= cfg_wdata[15:0];
        default:     damp_r  <= damp_r;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    limit_nxt = limit_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    trace_nxt = trace_r;
    acc_nxt   = acc_r;
    d_nxt     = d_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    cs_nxt    = cs_r;
    a_nxt     = a_r;
    neg_nxt   = neg_r;
    init_nxt  = init_r;
    bank_nxt  = bank_r;
    pass_nxt  = pass_r;
    conv_nxt  = conv_r;
    iss_nxt   = iss_r;
    new_nxt   = new_r;
    prev_nxt  = prev_r;
    taken_nxt = taken_r;
    best_nxt  = best_r;
    bidx_nxt  = bidx_r;
    hit_nxt   = hit_r;
    rnd_nxt   = rnd_r;
    wgt       = 17'h10000;

    out_load    = 1'b0;
    o_node_nxt  = '0;
    o_score_nxt = '0;
    o_gain_nxt  = '0;
    o_last_nxt  = 1'b0;
    o_conv_nxt  = 1'b0;
    o_err_nxt   = 1'b0;

    g_we  = 1'b0;
    g_wa  = {in_row_index[AW-1:0], in_col_index[AW-1:0]};
    g_ra  = sym_addr;
    t_we  = 1'b0;
    t_wd  = '0;
    cs_we = 1'b0;
    cs_wd = acc_nxt;
    r_we  = 1'b0;
    r_wa  = {1'b0, i_r};
    r_wd  = '0;
    r_ra  = {bank_r, j_r};

    div_req          = '0;
    div_req.rem_init = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_req_type) begin
            if (32'(in_row_index) < MAX_NODES && 32'(in_col_index) < MAX_NODES) begin
              g_we = 1'b1;
            end
          end else begin
            if (nodes_r == 7'd0) begin
              n_nxt = NW'(1);
            end else if (32'(nodes_r) > MAX_NODES) begin
              n_nxt = NW'(MAX_NODES);
            end else begin
              n_nxt = NW'(nodes_r);
            end
            limit_nxt = (iter_r == 16'd0) ? 16'd1 : iter_r;
            i_nxt     = '0;
            j_nxt     = '0;
            trace_nxt = '0;
            state_nxt = ST_CS_RD;
          end
        end
      end

      // Column sums and trace, column by column
      ST_CS_RD: state_nxt = ST_CS_ACC;
      ST_CS_ACC: begin
        acc_nxt = ((i_r == '0) ? '0 : acc_r) + CSW'(g);
        cs_wd   = acc_nxt;
        if (i_r == j_r) begin
          trace_nxt = trace_r + CSW'(g);
        end
        if (i_r == nm1) begin
          cs_we = 1'b1;
          i_nxt = '0;
          if (j_r == nm1) begin
            state_nxt = ST_TR_CHK;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_CS_RD;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_CS_RD;
        end
      end
      ST_TR_CHK: begin
        i_nxt = '0;
        j_nxt = '0;
        state_nxt = (trace_r == '0) ? ST_ERR_OUT : ST_TB_D1;
      end
      ST_ERR_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_last_nxt = 1'b1;
          o_err_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end

      // Transition matrix build, row by row
      ST_TB_D1: begin
        g_ra      = {i_r, i_r};
        state_nxt = ST_TB_D2;
      end
      ST_TB_D2: begin
        d_nxt     = g;
        j_nxt     = '0;
        state_nxt = ST_TB_RD;
      end
      ST_TB_RD: state_nxt = ST_TB_MUL;
      ST_TB_MUL: begin
        cs_nxt = $signed(csmem_rd);
        wgt    = (csmem_rd != '0) ? 17'(17'h10000 - {1'b0, damp_r}) : 17'h10000;
        pa_nxt = $signed({1'b0, damp_r}) * g;
        pb_nxt = d_r * $signed({1'b0, wgt});
        state_nxt = ST_TB_DA;
      end
      ST_TB_DA: begin
        if (cs_r == '0) begin
          a_nxt     = '0;
          state_nxt = ST_TB_DB;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = wpr_pkg::DIV_DVD_W'(pa_mag) << 12;
          div_req.divisor  = wpr_pkg::DIV_DSR_W'(cs_mag);
          div_req.steps    = wpr_pkg::DIV_STEP_W'(64);
          neg_nxt          = pa_r[48] ^ cs_r[CSW-1];
          state_nxt        = ST_TB_DAW;
        end
      end
      ST_TB_DAW: begin
        if (div_rsp.done) begin
          a_nxt     = qs;
          state_nxt = ST_TB_DB;
        end
      end
      ST_TB_DB: begin
        div_req.start    = 1'b1;
        div_req.dividend = wpr_pkg::DIV_DVD_W'(pb_mag) << 12;
        div_req.divisor  = wpr_pkg::DIV_DSR_W'(tr_mag);
        div_req.steps    = wpr_pkg::DIV_STEP_W'(64);
        neg_nxt          = pb_r[49] ^ trace_r[CSW-1];
        state_nxt        = ST_TB_DBW;
      end
      ST_TB_DBW: begin
        if (div_rsp.done) begin
          t_we = 1'b1;
          if (tsum > 64'sd2147483647) begin
            t_wd = 32'h7FFF_FFFF;
          end else if (tsum < -64'sd2147483648) begin
            t_wd = 32'h8000_0000;
          end else begin
            t_wd = tsum[31:0];
          end
          if (j_r == nm1) begin
            j_nxt = '0;
            if (i_r == nm1) begin
              i_nxt     = '0;
              state_nxt = ST_IN_DIV;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = ST_TB_D1;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_TB_RD;
          end
        end
      end

      // Start vector 1/N
      ST_IN_DIV: begin
        if (n_r == NW'(1)) begin
          init_nxt  = 32'hFFFF_FFFF;
          state_nxt = ST_IN_WR;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = wpr_pkg::DIV_REM_W'(1);
          div_req.divisor  = wpr_pkg::DIV_DSR_W'(n_r);
          div_req.steps    = wpr_pkg::DIV_STEP_W'(32);
          state_nxt        = ST_IN_DIVW;
        end
      end
      ST_IN_DIVW: begin
        if (div_rsp.done) begin
          init_nxt  = div_rsp.quot[31:0];
          state_nxt = ST_IN_WR;
        end
      end
      ST_IN_WR: begin
        r_we = 1'b1;
        r_wa = {1'b0, i_r};
        r_wd = init_r;
        if (i_r == nm1) begin
          bank_nxt  = 1'b0;
          pass_nxt  = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          iss_nxt   = 1'b1;
          conv_nxt  = 1'b1;
          state_nxt = ST_MV;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      // Matrix-vector: issue one element a cycle, drain, normalize if total != 0
      ST_MV: begin
        r_ra = {bank_r, j_r};
        if (iss_r) begin
          if (j_r == nm1) begin
            j_nxt = '0;
            if (i_r == nm1) begin
              iss_nxt = 1'b0;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else if (!s1_v_r && !s2_v_r) begin
          i_nxt = '0;
          j_nxt = '0;
          if (total_r == '0) begin
            // rank vector unchanged: the pass converges
            pass_nxt  = pass_r + 1'b1;
            taken_nxt = '0;
            hit_nxt   = 1'b0;
            rnd_nxt   = '0;
            state_nxt = ST_SR_RD;
          end else begin
            state_nxt = ST_NM_RD;
          end
        end
      end
      ST_NM_RD: begin
        r_ra      = {bank_r, i_r};
        state_nxt = ST_NM_CALC;
      end
      ST_NM_CALC: begin
        r_ra     = {bank_r, i_r};
        prev_nxt = rmem_rd;
        if (y == '0 || (y[SW-1] != total_r[TW-1])) begin
          new_nxt   = '0;
          state_nxt = ST_NM_WR;
        end else if (y_mag >= tot_mag) begin
          new_nxt   = 32'hFFFF_FFFF;
          state_nxt = ST_NM_WR;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = wpr_pkg::DIV_REM_W'(y_mag);
          div_req.divisor  = wpr_pkg::DIV_DSR_W'(tot_mag);
          div_req.steps    = wpr_pkg::DIV_STEP_W'(32);
          state_nxt        = ST_NM_WAIT;
        end
      end
      ST_NM_WAIT: begin
        if (div_rsp.done) begin
          new_nxt   = div_rsp.quot[31:0];
          state_nxt = ST_NM_WR;
        end
      end
      ST_NM_WR: begin
        r_we = 1'b1;
        r_wa = {~bank_r, i_r};
        r_wd = new_r;
        if (diff >= thr_r) begin
          conv_nxt = 1'b0;
        end
        if (i_r == nm1) begin
          bank_nxt = ~bank_r;
          pass_nxt = pass_r + 1'b1;
          i_nxt    = '0;
          j_nxt    = '0;
          if (conv_nxt || pass_nxt >= limit_r) begin
            taken_nxt = '0;
            hit_nxt   = 1'b0;
            rnd_nxt   = '0;
            state_nxt = ST_SR_RD;
          end else begin
            iss_nxt   = 1'b1;
            conv_nxt  = 1'b1;
            state_nxt = ST_MV;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_NM_RD;
        end
      end

      // Selection sort: one scan per result, strict compare keeps lower index
      ST_SR_RD: begin
        r_ra      = {bank_r, j_r};
        state_nxt = ST_SR_CMP;
      end
      ST_SR_CMP: begin
        r_ra = {bank_r, j_r};
        if (!taken_r[j_r] && (!hit_r || rmem_rd > best_r)) begin
          best_nxt = rmem_rd;
          bidx_nxt = j_r;
          hit_nxt  = 1'b1;
        end
        if (j_r == nm1) begin
          j_nxt     = '0;
          state_nxt = ST_SR_G1;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_SR_RD;
        end
      end
      ST_SR_G1: begin
        g_ra      = {bidx_r, bidx_r};
        state_nxt = ST_SR_G2;
      end
      ST_SR_G2: begin
        g_ra = {bidx_r, bidx_r};
        if (out_free) begin
          out_load    = 1'b1;
          o_node_nxt  = 6'(bidx_r);
          o_score_nxt = best_r;
          o_gain_nxt  = gmem_rd;
          o_conv_nxt  = conv_r;
          o_last_nxt  = rnd_r == nm1;
          taken_nxt[bidx_r] = 1'b1;
          hit_nxt     = 1'b0;
          if (rnd_r == nm1) begin
            state_nxt = ST_IDLE;
          end else begin
            rnd_nxt   = rnd_r + 1'b1;
            state_nxt = ST_SR_RD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Accumulate one row of T*r; clear the total before each pass
  always_comb begin
    mvacc_nxt = mvacc_r;
    total_nxt = total_r;
    s_we      = 1'b0;
    s_wd      = '0;
    if (state_r == ST_IN_WR || (state_r == ST_NM_WR && i_r == nm1)) begin
      total_nxt = '0;
    end
    if (s2_v_r) begin
      mvacc_nxt = (s2_first_r ? '0 : mvacc_r) + term;
      if (s2_last_r) begin
        s_we      = 1'b1;
        s_wd      = mvacc_nxt;
        total_nxt = total_r + TW'(mvacc_nxt);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      s1_v_r      <= (state_r == ST_MV) && iss_r;
      s2_v_r      <= s1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    limit_r    <= limit_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    trace_r    <= trace_nxt;
    acc_r      <= acc_nxt;
    d_r        <= d_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    cs_r       <= cs_nxt;
    a_r        <= a_nxt;
    neg_r      <= neg_nxt;
    init_r     <= init_nxt;
    bank_r     <= bank_nxt;
    pass_r     <= pass_nxt;
    conv_r     <= conv_nxt;
    total_r    <= total_nxt;
    mvacc_r    <= mvacc_nxt;
    new_r      <= new_nxt;
    prev_r     <= prev_nxt;
    taken_r    <= taken_nxt;
    best_r     <= best_nxt;
    bidx_r     <= bidx_nxt;
    hit_r      <= hit_nxt;
    rnd_r      <= rnd_nxt;
    s1_first_r <= j_r == '0;
    s1_last_r  <= j_r == nm1;
    s1_i_r     <= i_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_i_r     <= s1_i_r;
    prod_r     <= 64'($signed(tmem_rd) * $signed({1'b0, rmem_rd}));
    if (out_load) begin
      out_node_index  <= o_node_nxt;
      out_rank_score  <= o_score_nxt;
      out_info_gain   <= $signed(o_gain_nxt);
      out_last_of_run <= o_last_nxt;
      out_converged   <= o_conv_nxt;
      out_error_flag  <= o_err_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Gain store: written from the input channel, read by the sequencer
  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_wa] <= in_gain_value;
    end
    gmem_rd <= gmem[g_ra];
  end

  // Transition store, Q4.28
  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[{i_r, j_r}] <= t_wd;
    end
    tmem_rd <= tmem[{i_r, j_r}];
  end

  // Column sums
  always_ff @(posedge clk) begin
    if (cs_we) begin
      csmem[j_r] <= cs_wd;
    end
    csmem_rd <= csmem[j_r];
  end

  // Row sums of one pass
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s2_i_r] <= s_wd;
    end
    smem_rd <= smem[i_r];
  end

  // Rank vector, two banks: current and previous
  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_wa] <= r_wd;
    end
    rmem_rd <= rmem[r_ra];
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_flag) |-> (out_last_of_run && !out_converged &&
      out_rank_score == 32'd0))
    else $error("error word fields wrong");

  a_stream_in_mv: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> state_r == ST_MV)
    else $error("row stream active outside matrix-vector phase");

  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MV) |-> pass_r < limit_r)
    else $error("pass count beyond limit");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int NODES = 64;
  // Corner of the matrix whose upper triangle is fully written.
  localparam int LOAD_NODES = 11;

  // Register indexes of the configuration port.
  localparam bit [1:0] REG_DAMPING   = 2'd0;
  localparam bit [1:0] REG_THRESHOLD = 2'd1;
  localparam bit [1:0] REG_NODES     = 2'd2;
  localparam bit [1:0] REG_LIMIT     = 2'd3;

  // Word kinds on the input channel.
  localparam bit REQ_WRITE = 1'b0;
  localparam bit REQ_START = 1'b1;

  typedef struct {
    bit [5:0]  node;
    bit [31:0] score;
    bit [31:0] gain;
    bit        last;
    bit        conv;
    bit        err;
  } rank_word_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_req_type = 1'b0;
  logic [5:0]         in_row_index = '0;
  logic [5:0]         in_col_index = '0;
  logic signed [31:0] in_gain_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_node_index;
  logic [31:0]        out_rank_score;
  logic signed [31:0] out_info_gain;
  logic               out_last_of_run;
  logic               out_converged;
  logic               out_error_flag;

  weighted_pagerank_power_iteration_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_gain_value   (in_gain_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_index  (out_node_index),
    .out_rank_score  (out_rank_score),
    .out_info_gain   (out_info_gain),
    .out_last_of_run (out_last_of_run),
    .out_converged   (out_converged),
    .out_error_flag  (out_error_flag)
  );

  // Mirror of the block's registers and gain store; the store follows accepted words.
  bit [15:0] damping;
  bit [31:0] threshold;
  bit [6:0]  node_count;
  bit [15:0] pass_limit;
  int        gain_mem [NODES][NODES];

  rank_word_t ranked_q[$];

  int gap_pct;
  int stall_pct;
  int n_errors;
  int n_writes;
  int n_starts;
  int n_checked;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #200_000_000;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure: redraw every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic longint sym_gain(int i, int j);
    return (i <= j) ? longint'(gain_mem[i][j]) : longint'(gain_mem[j][i]);
  endfunction

  // Compute the ranked words of one run from the mirrored matrix.
  function automatic void predict_ranking();
    int         n, lim, pass, k;
    longint     trace, gam, wnz, total, a, b, t, d, y;
    longint     col_sum [NODES];
    longint     row_sum [NODES];
    int         trans [NODES][NODES];
    bit [31:0]  cur [NODES];
    bit [31:0]  prv [NODES];
    bit [31:0]  diff;
    bit [63:0]  num, den, init;
    bit [95:0]  quo;
    int         order [NODES];
    bit         conv;
    rank_word_t w;

    n = (node_count == 0) ? 1 : ((node_count > NODES) ? NODES : int'(node_count));
    lim = (pass_limit == 0) ? 1 : int'(pass_limit);

    trace = 0;
    for (int i = 0; i < n; i++) trace += sym_gain(i, i);
    for (int j = 0; j < n; j++) begin
      col_sum[j] = 0;
      for (int i = 0; i < n; i++) col_sum[j] += sym_gain(i, j);
    end
    if (trace == 0) begin
      w = '{node: 0, score: 0, gain: 0, last: 1, conv: 0, err: 1};
      ranked_q.push_back(w);
      return;
    end

    gam = longint'(damping);
    wnz = 65536 - gam;
    for (int i = 0; i < n; i++) begin
      d = sym_gain(i, i);
      for (int j = 0; j < n; j++) begin
        a = 0;
        if (col_sum[j] != 0) a = (gam * sym_gain(i, j) * 4096) / col_sum[j];
        b = (d * ((col_sum[j] != 0) ? wnz : 65536) * 4096) / trace;
        t = a + b;
        if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
        if (t < -64'sh80000000) t = -64'sh80000000;
        trans[i][j] = int'(t);
      end
    end

    init = (64'd1 << 32) / n;
    if (init > 64'hFFFFFFFF) init = 64'hFFFFFFFF;
    for (int i = 0; i < n; i++) cur[i] = init[31:0];

    conv = 1'b0;
    for (pass = 0; pass < lim && !conv; pass++) begin
      for (int i = 0; i < n; i++) prv[i] = cur[i];
      total = 0;
      for (int i = 0; i < n; i++) begin
        row_sum[i] = 0;
        for (int j = 0; j < n; j++)
          row_sum[i] += (longint'(trans[i][j]) * longint'(prv[j])) >>> 28;
        total += row_sum[i];
      end
      // A zero total leaves the vector as it was.
      if (total != 0) begin
        den = (total < 0) ? -total : total;
        for (int i = 0; i < n; i++) begin
          y = row_sum[i];
          num = (y < 0) ? -y : y;
          if (y == 0 || ((y < 0) != (total < 0))) cur[i] = '0;
          else if (num >= den) cur[i] = '1;
          else begin
            quo = {num, 32'd0} / den;
            cur[i] = quo[31:0];
          end
        end
      end
      conv = 1'b1;
      for (int i = 0; i < n; i++) begin
        diff = (cur[i] >= prv[i]) ? cur[i] - prv[i] : prv[i] - cur[i];
        if (diff >= threshold) conv = 1'b0;
      end
    end

    // Stable insertion: descending score, lower index first on ties.
    for (int i = 0; i < n; i++) begin
      k = i;
      while (k > 0 && cur[order[k-1]] < cur[i]) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
    end
    for (int i = 0; i < n; i++) begin
      w.node  = 6'(order[i]);
      w.score = cur[order[i]];
      w.gain  = gain_mem[order[i]][order[i]];
      w.last  = (i == n - 1);
      w.conv  = conv;
      w.err   = 1'b0;
      ranked_q.push_back(w);
    end
  endfunction

  // Check every word that leaves the block against the oldest prediction.
  always @(posedge clk) begin
    rank_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (ranked_q.size() == 0) begin
        $display("%0t: unexpected word node %0d score %h", $time, out_node_index,
                 out_rank_score);
        n_errors++;
      end else begin
        w = ranked_q.pop_front();
        n_checked++;
        if (out_node_index !== w.node || out_rank_score !== w.score ||
            out_info_gain !== w.gain || out_last_of_run !== w.last ||
            out_converged !== w.conv || out_error_flag !== w.err) begin
          $display("%0t: mismatch exp node %0d score %h gain %h last %b conv %b err %b",
                   $time, w.node, w.score, w.gain, w.last, w.conv, w.err);
          $display("%0t:          got node %0d score %h gain %h last %b conv %b err %b",
                   $time, out_node_index, out_rank_score, out_info_gain,
                   out_last_of_run, out_converged, out_error_flag);
          n_errors++;
        end
      end
    end
  end

  // Send one word; hold it until accepted, then update the mirror.
  task automatic send_word(bit kind, bit [5:0] row, bit [5:0] col, bit [31:0] gain);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_row_index  <= row;
    in_col_index  <= col;
    in_gain_value <= gain;
    do @(posedge clk); while (in_stall);
    if (kind == REQ_WRITE) begin
      gain_mem[row][col] = gain;
      n_writes++;
    end else begin
      predict_ranking();
      n_starts++;
    end
  endtask

  // Drop valid and wait until every predicted word has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_regs(bit [15:0] damp, bit [31:0] thr, bit [6:0] nodes,
                            bit [15:0] lim);
    bit [31:0] vals [4];
    vals = '{32'(damp), thr, 32'(nodes), 32'(lim)};
    for (int r = 0; r < 4; r++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= r[1:0];
      cfg_wdata <= vals[r];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    damping = damp;
    threshold = thr;
    node_count = nodes;
    pass_limit = lim;
  endtask

  function automatic bit [31:0] rand_gain();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(1, 32'h0004_0000);
      2: return -$urandom_range(1, 32'h0002_0000);
      3: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h0000_8000, 32'h0003_0000);
    endcase
  endfunction

  // Write the upper triangle of the used corner so no unwritten entry is read.
  task automatic test_load_matrix();
    for (int r = 0; r < LOAD_NODES; r++)
      for (int c = r; c < LOAD_NODES; c++)
        send_word(REQ_WRITE, 6'(r), 6'(c), $urandom_range(1, 32'h0002_0000));
  endtask

  task automatic test_directed();
    drain();
    write_regs(16'd55706, 32'd429497, 7'd2, 16'd20);
    // Zero trace gives a single error word.
    send_word(REQ_WRITE, 0, 0, 32'd0);
    send_word(REQ_WRITE, 1, 1, 32'd0);
    send_word(REQ_START, 0, 0, 32'd0);
    drain();
    // Zero column sum on column 0; a lower-triangle write is stored but unused.
    send_word(REQ_WRITE, 0, 0, 32'h0001_0000);
    send_word(REQ_WRITE, 0, 1, 32'hFFFF_0000);
    send_word(REQ_WRITE, 1, 1, 32'h0002_0000);
    send_word(REQ_WRITE, 1, 0, 32'h1234_5678);
    send_word(REQ_START, 0, 0, 32'd0);
    drain();
    // Field extremes: saturating transition terms, full damping, tightest limit.
    write_regs(16'hFFFF, 32'd1, 7'd3, 16'd0);
    send_word(REQ_WRITE, 0, 2, 32'h8000_0000);
    send_word(REQ_WRITE, 2, 2, 32'h7FFF_FFFF);
    send_word(REQ_WRITE, 63, 63, 32'hFFFF_FFFF);
    send_word(REQ_WRITE, 63, 0, 32'h0000_0001);
    send_word(REQ_START, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
    drain();
    // Zero damping, loosest threshold with the largest pass limit.
    write_regs(16'd0, 32'hFFFF_FFFF, 7'd4, 16'hFFFF);
    send_word(REQ_START, 0, 0, 32'd0);
    drain();
    // Node count zero acts as one: the lone score saturates.
    write_regs(16'd30000, 32'd1000, 7'd0, 16'd5);
    send_word(REQ_START, 0, 0, 32'd0);
    drain();
    write_regs(16'd55706, 32'd429497, 7'd1, 16'd5);
    send_word(REQ_START, 0, 0, 32'd0);
    drain();
  endtask

  // One idling mode: batches of writes, mostly into the active corner, then a start.
  task automatic test_random_phase(int gap, int stall, int runs);
    int        nn, cnt;
    bit [5:0]  r, c, t;
    bit [31:0] thr;
    gap_pct = gap;
    stall_pct = stall;
    for (int k = 0; k < runs; k++) begin
      drain();
      nn = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      case ($urandom_range(2))
        0: thr = $urandom();
        1: thr = $urandom_range(1, 2000);
        default: thr = 32'hFFFF_FFFF;
      endcase
      write_regs(16'($urandom_range(16'hFFFF)), thr, 7'(nn), 16'($urandom_range(0, 12)));
      cnt = $urandom_range(1, 6);
      for (int w = 0; w < cnt; w++) begin
        if ($urandom_range(4) == 0) begin
          send_word(REQ_WRITE, 6'($urandom_range(63)), 6'($urandom_range(63)), $urandom());
        end else begin
          r = 6'($urandom_range((nn > 0) ? nn - 1 : 0));
          c = 6'($urandom_range((nn > 0) ? nn - 1 : 0));
          if (r > c) begin
            t = r; r = c; c = t;
          end
          send_word(REQ_WRITE, r, c, rand_gain());
        end
      end
      send_word(REQ_START, 6'($urandom_range(63)), 6'($urandom_range(63)), $urandom());
    end
  endtask

  // Largest loaded corner in one run; one pass only.
  task automatic test_full_size();
    gap_pct = 0;
    stall_pct = 0;
    drain();
    write_regs(16'd55706, 32'd429497, 7'(LOAD_NODES), 16'd1);
    send_word(REQ_START, 0, 0, 32'd0);
  endtask

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    damping = 16'd55706;
    threshold = 32'd429497;
    node_count = 7'd64;
    pass_limit = 16'd1000;

    test_load_matrix();
    test_directed();
    test_random_phase(0, 0, 8);
    test_random_phase(50, 0, 8);
    test_random_phase(0, 50, 8);
    test_random_phase(9, 9, 8);
    test_full_size();
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d element writes and %0d ranking runs; %0d result words checked.",
             n_writes, n_starts, n_checked);
    $display("Idling modes: none, sender gaps, receiver stalls, both; %0d mismatches.",
             n_errors);
    if (n_errors == 0 && ranked_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
